### hdl/basf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// basf_pkg
// Shared types, constants and tables of the advertisement structure filter.
// ----------------------------------------------------------------------------
package basf_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_W  = 16;
  localparam int WIN_W  = 48;
  localparam int FLAG_W = 5;

  localparam logic [CFG_W-1:0] COMPANY_ID_RESET = 16'h00C5;
  localparam int               FIFO_DEPTH_DEFAULT = 4;

  localparam logic [BYTE_W-1:0] AD_MANUFACTURER = 8'hFF;
  localparam logic [BYTE_W-1:0] AD_UUID128_PART = 8'h06;
  localparam logic [BYTE_W-1:0] AD_UUID128_FULL = 8'h07;
  localparam logic [BYTE_W-1:0] AD_NAME_SHORT   = 8'h08;
  localparam logic [BYTE_W-1:0] AD_NAME_FULL    = 8'h09;

  localparam logic [BYTE_W-1:0] VENDOR_ID_POS  = 8'd1;
  localparam logic [BYTE_W-1:0] SIGNATURE_POS  = 8'd9;
  localparam logic [BYTE_W-1:0] HINT_FIELD_LEN = 8'd23;
  localparam logic [31:0]       SIGNATURE      = 32'h0103_2202;

  localparam logic [31:0]      NAME_PAT_A = 32'h484F_424F;
  localparam logic [WIN_W-1:0] NAME_PAT_B = 48'h4D58_3230_3031;
  localparam logic [WIN_W-1:0] NAME_PAT_C = 48'h4D58_3232_3031;
  localparam logic [WIN_W-1:0] NAME_PAT_D = 48'h4D58_3232_3033;

  localparam int FLAG_VENDOR  = 0;
  localparam int FLAG_SERVICE = 1;
  localparam int FLAG_NAME    = 2;
  localparam int FLAG_HINT22  = 3;
  localparam int FLAG_SIG     = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] raw;
    logic [BYTE_W-1:0] folded;
    logic              is_zero;
    logic              last;
  } basf_item_t;

  function automatic logic [BYTE_W-1:0] uuid_byte(input logic [3:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      4'd0:    b = 8'hCF;
      4'd1:    b = 8'hCB;
      4'd2:    b = 8'hE6;
      4'd3:    b = 8'hBC;
      4'd4:    b = 8'hCC;
      4'd5:    b = 8'h83;
      4'd6:    b = 8'h49;
      4'd7:    b = 8'hAC;
      4'd8:    b = 8'h41;
      4'd9:    b = 8'h46;
      4'd10:   b = 8'h4E;
      4'd11:   b = 8'hED;
      4'd12:   b = 8'h4F;
      4'd13:   b = 8'h6E;
      4'd14:   b = 8'hE1;
      default: b = 8'h65;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

### hdl/basf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// basf_front
// Input side: accepts advertisement bytes and classifies them for the queue.
// ----------------------------------------------------------------------------
module basf_front
  import basf_pkg::*;
(
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [BYTE_W-1:0] s_axis_tdata,
  input  wire logic              s_axis_tlast,
  input  wire logic              q_full,
  output logic                   q_push,
  output basf_item_t             q_item
);

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  always_comb begin
    q_item.raw     = s_axis_tdata;
    q_item.is_zero = (s_axis_tdata == '0);
    q_item.last    = s_axis_tlast;
    if (s_axis_tdata >= 8'h61 && s_axis_tdata <= 8'h7A) begin
      q_item.folded = s_axis_tdata - 8'h20;
    end else begin
      q_item.folded = s_axis_tdata;
    end
  end

endmodule
`default_nettype wire

### hdl/basf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// basf_fifo
// Short queue of classified bytes between the input side and the parser.
// ----------------------------------------------------------------------------
module basf_fifo
  import basf_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire basf_item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output basf_item_t      head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  basf_item_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/basf_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// basf_parser
// Walks the length-type-payload structures and registers the result.
// ----------------------------------------------------------------------------
module basf_parser
  import basf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CFG_W-1:0] company_id,
  input  wire logic             q_valid,
  input  wire basf_item_t       q_item,
  output logic                  q_pop,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [BYTE_W-1:0]     m_axis_tdata
);

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_PAY,
    PH_HALT
  } phase_t;

  phase_t              phase, phase_next;
  logic [BYTE_W-1:0]   bytes_left, bytes_left_next;
  logic [BYTE_W-1:0]   field_len, field_len_next;
  logic [BYTE_W-1:0]   field_kind, field_kind_next;
  logic [BYTE_W-1:0]   payload_pos, payload_pos_next;
  logic                chunk_equal, chunk_equal_next;
  logic [WIN_W-1:0]    name_window, name_window_next;
  logic [FLAG_W-1:0]   pending, pending_next;
  logic [FLAG_W-1:0]   found, found_next;
  logic                is_name;
  logic                is_uuid;
  logic [CFG_W-1:0]    got_id;

  assign q_pop = q_valid && (!q_item.last || !m_axis_tvalid || m_axis_tready);

  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    field_len_next   = field_len;
    field_kind_next  = field_kind;
    payload_pos_next = payload_pos;
    chunk_equal_next = chunk_equal;
    name_window_next = name_window;
    pending_next     = pending;
    found_next       = found;
    is_name = (field_kind == AD_NAME_SHORT) || (field_kind == AD_NAME_FULL);
    is_uuid = (field_kind == AD_UUID128_PART) || (field_kind == AD_UUID128_FULL);
    got_id  = '0;

    case (phase)
      PH_LEN: begin
        if (q_item.is_zero) begin
          phase_next = PH_HALT;
        end else begin
          field_len_next  = q_item.raw;
          bytes_left_next = q_item.raw;
          phase_next      = PH_TYPE;
        end
      end
      PH_TYPE: begin
        field_kind_next  = q_item.raw;
        bytes_left_next  = bytes_left - 1'b1;
        payload_pos_next = '0;
        chunk_equal_next = 1'b1;
        name_window_next = '0;
        pending_next     = '0;
        phase_next       = (bytes_left == 8'd1) ? PH_LEN : PH_PAY;
      end
      PH_PAY: begin
        name_window_next = {name_window[WIN_W-BYTE_W-1:0],
                            is_name ? q_item.folded : q_item.raw};
        got_id = {name_window_next[7:0], name_window_next[15:8]};
        if (field_kind == AD_MANUFACTURER) begin
          if (payload_pos == VENDOR_ID_POS) begin
            if (got_id == company_id) begin
              pending_next[FLAG_VENDOR] = 1'b1;
            end
          end else if (payload_pos == SIGNATURE_POS) begin
            if (pending[FLAG_VENDOR] && name_window_next[31:0] == SIGNATURE) begin
              pending_next[FLAG_SIG] = 1'b1;
            end
          end
        end
        if (is_uuid) begin
          chunk_equal_next = chunk_equal && (q_item.raw == uuid_byte(payload_pos[3:0]));
          if (payload_pos[3:0] == 4'hF) begin
            if (chunk_equal_next) begin
              pending_next[FLAG_SERVICE] = 1'b1;
            end
            chunk_equal_next = 1'b1;
          end
        end
        if (is_name) begin
          if (name_window_next[31:0] == NAME_PAT_A || name_window_next == NAME_PAT_B ||
              name_window_next == NAME_PAT_C || name_window_next == NAME_PAT_D) begin
            pending_next[FLAG_NAME] = 1'b1;
          end
        end
        bytes_left_next  = bytes_left - 1'b1;
        payload_pos_next = payload_pos + 1'b1;
        if (bytes_left == 8'd1) begin
          if (pending_next[FLAG_VENDOR] && field_len == HINT_FIELD_LEN) begin
            pending_next[FLAG_HINT22] = 1'b1;
          end
          found_next   = found | pending_next;
          pending_next = '0;
          phase_next   = PH_LEN;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEN;
      bytes_left    <= '0;
      field_len     <= '0;
      field_kind    <= '0;
      payload_pos   <= '0;
      chunk_equal   <= 1'b1;
      name_window   <= '0;
      pending       <= '0;
      found         <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
    end else begin
      if (q_pop && q_item.last) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (q_pop) begin
        if (q_item.last) begin
          phase         <= PH_LEN;
          bytes_left    <= '0;
          field_len     <= '0;
          field_kind    <= '0;
          payload_pos   <= '0;
          chunk_equal   <= 1'b1;
          name_window   <= '0;
          pending       <= '0;
          found         <= '0;
          m_axis_tdata  <= {2'b00,
                            found_next[FLAG_SIG],
                            found_next[FLAG_HINT22],
                            found_next[FLAG_NAME],
                            found_next[FLAG_SERVICE],
                            found_next[FLAG_VENDOR],
                            found_next[FLAG_VENDOR] | found_next[FLAG_SERVICE] |
                            found_next[FLAG_NAME]};
        end else begin
          phase       <= phase_next;
          bytes_left  <= bytes_left_next;
          field_len   <= field_len_next;
          field_kind  <= field_kind_next;
          payload_pos <= payload_pos_next;
          chunk_equal <= chunk_equal_next;
          name_window <= name_window_next;
          pending     <= pending_next;
          found       <= found_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/ble_adv_structure_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ble_adv_structure_filter
// Parses advertisement structures and flags vendor, service and name matches.
// Result path: the last byte is written into the queue; the parser pops it
// and registers the flags on the output.
// Throughput: one byte per cycle, stalled while a result waits unaccepted.
// Reset: synchronous; queue empty, parser cleared, company ID back to 0x00C5.
// ----------------------------------------------------------------------------
module ble_adv_structure_filter
  import basf_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [BYTE_W-1:0] s_axis_tdata,   // adv_byte
  input  wire logic              s_axis_tlast,   // last_byte
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [BYTE_W-1:0]      m_axis_tdata,   // is_candidate, vendor_match,
                                                 // service_match, name_match,
                                                 // hint_length_22, hint_signature
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] company_id;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  basf_item_t       push_item;
  basf_item_t       head_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      company_id <= COMPANY_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      company_id <= cfg_data;
    end
  end

  basf_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  basf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  basf_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .company_id    (company_id),
    .q_valid       (q_valid),
    .q_item        (head_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire
